// ===== rtl/pse_pkg.sv =====
package pse_pkg;

	localparam int WORD_W          = 32;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int DIV_STEPS       = WORD_W;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		KIND_OPERAND  = 1'b0,
		KIND_OPERATOR = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_DIV  = 2'd2,
		S_DONE = 2'd3
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic div_start;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_busy;
	} sts_t;

endpackage

// ===== rtl/pse_div.sv =====
module pse_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pse_pkg::WORD_W-1:0]   dividend,
	input  logic [pse_pkg::WORD_W-1:0]   divisor,
	output logic                         busy,
	output logic [pse_pkg::WORD_W-1:0]   quotient
);

	localparam int W  = pse_pkg::WORD_W;
	localparam int CW = pse_pkg::DIV_CNT_W;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dm_q;
	logic          neg_q;

	logic [W-1:0]  nm;
	logic [W-1:0]  dm;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	// magnitudes; the most negative value maps onto itself as an unsigned word
	assign nm = dividend[W-1] ? (~dividend + W'(1)) : dividend;
	assign dm = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= nm;
			dm_q  <= dm;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

// ===== rtl/pse_dpath.sv =====
module pse_dpath #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pse_pkg::cmd_t                     cmd,
	output pse_pkg::sts_t                     sts,
	input  logic                              kind,
	input  logic signed [pse_pkg::WORD_W-1:0] operand_value,
	input  logic [1:0]                        operator_code,
	input  logic                              end_of_expression,
	output logic signed [pse_pkg::WORD_W-1:0] top_value,
	output logic [1:0]                        status,
	output logic                              final_result
);

	localparam int W  = pse_pkg::WORD_W;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// top of stack lives in top_q; entries below it live in the memory
	logic [W-1:0]     mem [STACK_DEPTH];
	logic [W-1:0]     rd_q;
	logic [W-1:0]     top_q;
	logic [CW-1:0]    cnt_q;

	pse_pkg::kind_t   tok_kind_q;
	logic [W-1:0]     tok_val_q;
	pse_pkg::op_t     tok_opc_q;
	logic             tok_last_q;

	logic [W-1:0]     res_q;
	pse_pkg::status_t st_q;
	logic             div_sel_q;

	logic [W-1:0]     out_top_q;
	pse_pkg::status_t out_st_q;
	logic             out_last_q;

	logic [W-1:0]     right;
	logic [W-1:0]     left;
	logic             has_one;
	logic             has_two;
	logic             full;
	logic             under;
	logic [W-1:0]     res_d;
	pse_pkg::status_t st_d;
	logic             need_div;
	logic [W-1:0]     quotient;
	logic             div_busy;
	logic [W-1:0]     op_res;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;

	assign has_one = (cnt_q != '0);
	assign has_two = (cnt_q > CW'(1));
	assign full    = (cnt_q == CW'(STACK_DEPTH));
	assign right   = has_one ? top_q : '0;
	assign left    = has_two ? rd_q : '0;
	assign under   = (tok_kind_q == pse_pkg::KIND_OPERATOR) && !has_two;
	assign rd_addr = AW'(cnt_q - CW'(2));
	assign wr_addr = AW'(cnt_q - CW'(1));

	always_comb begin
		res_d    = '0;
		st_d     = pse_pkg::ST_OK;
		need_div = 1'b0;
		if (tok_kind_q == pse_pkg::KIND_OPERAND) begin
			res_d = tok_val_q;
			if (full) begin
				st_d = pse_pkg::ST_OVERFLOW;
			end
		end else begin
			case (tok_opc_q)
				pse_pkg::OP_ADD: res_d = left + right;
				pse_pkg::OP_SUB: res_d = left - right;
				pse_pkg::OP_MUL: res_d = left * right;
				pse_pkg::OP_DIV: begin
					if (right == '0) begin
						st_d = pse_pkg::ST_DIVZERO;
					end else if (!under) begin
						need_div = 1'b1;
					end
				end
				default: res_d = '0;
			endcase
			// an underflowed divide always yields zero
			if (under) begin
				st_d = pse_pkg::ST_UNDERFLOW;
			end
		end
	end

	assign sts.need_div = need_div;
	assign sts.div_busy = div_busy;

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (left),
		.divisor  (right),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign op_res = div_sel_q ? quotient : res_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.commit && tok_kind_q == pse_pkg::KIND_OPERAND && !full && has_one) begin
			mem[wr_addr] <= top_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tok_kind_q <= pse_pkg::kind_t'(kind);
			tok_val_q  <= operand_value;
			tok_opc_q  <= pse_pkg::op_t'(operator_code);
			tok_last_q <= end_of_expression;
		end
		if (cmd.exec) begin
			res_q     <= res_d;
			st_q      <= st_d;
			div_sel_q <= need_div;
		end
		if (cmd.commit) begin
			out_st_q   <= st_q;
			out_last_q <= tok_last_q;
			if (tok_kind_q == pse_pkg::KIND_OPERAND) begin
				if (!full) begin
					top_q     <= res_q;
					out_top_q <= res_q;
				end else begin
					out_top_q <= top_q;
				end
			end else begin
				top_q     <= op_res;
				out_top_q <= op_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.commit) begin
			if (tok_last_q) begin
				cnt_q <= '0;
			end else if (tok_kind_q == pse_pkg::KIND_OPERAND) begin
				if (!full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (has_two) begin
				cnt_q <= cnt_q - CW'(1);
			end else begin
				cnt_q <= CW'(1);
			end
		end
	end

	assign top_value    = out_top_q;
	assign status       = out_st_q;
	assign final_result = out_last_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && tok_last_q |=> cnt_q == '0)
		else $error("stack not cleared after last token");

	a_op_pops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !tok_last_q && tok_kind_q == pse_pkg::KIND_OPERATOR && has_two
		|=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("operator did not net one pop");

	a_div_idle_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !div_busy)
		else $error("commit while divider busy");
`endif

endmodule

// ===== rtl/pse_ctrl.sv =====
module pse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output pse_pkg::cmd_t cmd,
	input  pse_pkg::sts_t sts
);

	pse_pkg::state_t state_q;
	pse_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			pse_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = pse_pkg::S_EXEC;
				end
			end
			pse_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = pse_pkg::S_DIV;
				end else begin
					state_d = pse_pkg::S_DONE;
				end
			end
			pse_pkg::S_DIV: begin
				if (!sts.div_busy) begin
					state_d = pse_pkg::S_DONE;
				end
			end
			pse_pkg::S_DONE: begin
				// result register frees up on the beat that drains it
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = pse_pkg::S_IDLE;
				end
			end
			default: state_d = pse_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ready)
		else $error("result overwritten before taken");

	a_div_start_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == pse_pkg::S_DIV && sts.div_busy)
		else $error("divider not running after start");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && state_q == pse_pkg::S_IDLE)
		else $error("commit did not present result");
`endif

endmodule

// ===== rtl/postfix_stack_evaluator_unit.sv =====
// Postfix expression evaluator on a hardware operand stack.
// Input channel (in_valid/in_ready) takes one token per beat: kind selects
// an operand push (operand_value) or an operator (operator_code: add, sub,
// mul, truncating div) that pops two entries and pushes left op right.
// end_of_expression marks the last token; its result carries final_result
// and the stack is emptied afterwards.
// Output channel (out_valid/out_ready) returns one beat per token: the new
// top of stack (0 if empty) and a status of ok, overflow, underflow or
// divide by zero.
// Each token is loaded, executed into the result register and committed
// to the output register; a divide waits between execute and commit for
// the divider, which retires one quotient bit per cycle. One token is in
// flight at a time: the next is taken only after the last has committed.
// The next token is taken while a finished result waits in the output
// register; if the receiver stalls, that next token completes its work and
// then holds until the output register drains.
// Reset empties the stack and drops any pending result; the stack memory
// itself is not cleared.
module postfix_stack_evaluator_unit #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic signed [pse_pkg::WORD_W-1:0] operand_value,
	input  logic [1:0]                        operator_code,
	input  logic                              end_of_expression,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pse_pkg::WORD_W-1:0] top_value,
	output logic [1:0]                        status,
	output logic                              final_result
);

	pse_pkg::cmd_t cmd;
	pse_pkg::sts_t sts;

	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pse_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.kind              (kind),
		.operand_value     (operand_value),
		.operator_code     (operator_code),
		.end_of_expression (end_of_expression),
		.top_value         (top_value),
		.status            (status),
		.final_result      (final_result)
	);

endmodule
